[hw/rtl/mptq_pkg.sv]
// Shared types, sizes and codes for the min-priority table queue.
// Used by mptq_cell and min_priority_table_queue; depends on nothing.
package mptq_pkg;

  // Table size and stored widths
  localparam int DEPTH       = 16;
  localparam int TAG_BITS    = 16;
  localparam int TAG_FIELD_W = 16;
  localparam int PRIO_W      = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef logic [TAG_BITS-1:0]      tag_t;
  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Request kinds
  localparam logic [1:0] KIND_ENQ   = 2'd0;
  localparam logic [1:0] KIND_DEQ   = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_NOMATCH = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // Best-so-far candidate handed from newer cells toward slot 0
  typedef struct packed {
    logic  vld;
    idx_t  slot;
    tag_t  tag;
    prio_t prio;
  } cand_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic  enq;
    logic  shift;
    logic  lower;
    tag_t  tag;
    prio_t prio;
    cnt_t  count;
    idx_t  take_slot;
  } cmd_t;

endpackage

[hw/rtl/min_priority_table_queue.sv]
// Min-priority queue over an unsorted table built as a row of slot cells.
// Depends on mptq_pkg and mptq_cell.
//
// Usage: one request beat on the s_axis side gives exactly one result beat
// on the m_axis side. tuser carries the request kind (enqueue, dequeue most
// urgent, lower priority, clear) and, on the result, the status code.
// Entries are kept oldest in slot 0; the most urgent entry is the one with
// the smallest priority, the newest of them on a tie.
// Timing: a request is taken only while the block is idle. Enqueue, lower
// and clear apply the request and then run one minimum scan; a dequeue on a
// non-empty table runs one scan before the apply step as well. The next
// request is accepted in the cycle after the result is loaded. The scans set
// the pace: the best candidate walks down the cell row one slot per cycle,
// and a dequeue needs one scan to find the entry and one to find the new best.
// The result sits in an output register; the next request can be accepted
// and processed while it waits, and the block holds at the end of that next
// scan until the receiver takes the pending beat.
// Reset empties the table (count zero) and drops any pending result.
module min_priority_table_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] value_tag, [47:16] prio_in
  input  logic [47:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] taken_tag, [47:16] taken_prio, [63:48] best_tag, [95:64] best_prio,
  // [100:96] count, [101] empty_res, [103:102] zero
  output logic [103:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);
  import mptq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state_q;
  cnt_t       scan_cnt_q;
  cnt_t       count_q;
  logic [1:0] kind_q;
  tag_t       tag_q;
  prio_t      prio_q;
  logic [1:0] status_q;
  tag_t       taken_tag_q;
  prio_t      taken_prio_q;

  logic                   out_vld_q;
  logic [1:0]             o_status_q;
  logic [TAG_FIELD_W-1:0] o_taken_tag_q;
  prio_t                  o_taken_prio_q;
  logic [TAG_FIELD_W-1:0] o_best_tag_q;
  prio_t                  o_best_prio_q;
  cnt_t                   o_count_q;
  logic                   o_empty_q;

  cmd_t  cmd;
  tag_t  tag_w   [DEPTH+1];
  prio_t prio_w  [DEPTH+1];
  cand_t carry_w [DEPTH+1];
  logic  hit_w   [DEPTH+1];

  logic in_acc;
  logic scan_done;
  logic out_free;
  logic load_out;
  logic not_full;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign scan_done     = (scan_cnt_q == cnt_t'(DEPTH));
  assign out_free      = !out_vld_q || m_axis_tready;
  assign load_out      = (state_q == S_SCAN) && scan_done && out_free;
  assign not_full      = (count_q < cnt_t'(DEPTH));

  // Broadcast command to the cell row
  always_comb begin
    cmd.enq       = (state_q == S_EXEC) && (kind_q == KIND_ENQ) && not_full;
    cmd.shift     = (state_q == S_EXEC) && (kind_q == KIND_DEQ) && (count_q != '0);
    cmd.lower     = (state_q == S_EXEC) && (kind_q == KIND_LOWER);
    cmd.tag       = tag_q;
    cmd.prio      = prio_q;
    cmd.count     = count_q;
    cmd.take_slot = carry_w[0].slot;
  end

  // Tie off the newest end of the row
  assign tag_w[DEPTH]   = '0;
  assign prio_w[DEPTH]  = '0;
  assign carry_w[DEPTH] = '0;
  assign hit_w[DEPTH]   = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mptq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (idx_t'(g)),
      .cmd_i     (cmd),
      .nb_tag_i  (tag_w[g+1]),
      .nb_prio_i (prio_w[g+1]),
      .carry_i   (carry_w[g+1]),
      .hit_i     (hit_w[g+1]),
      .tag_o     (tag_w[g]),
      .prio_o    (prio_w[g]),
      .carry_o   (carry_w[g]),
      .hit_o     (hit_w[g])
    );
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      tag_q  <= tag_t'(s_axis_tdata[15:0]);
      prio_q <= prio_t'(s_axis_tdata[47:16]);
    end
  end

  // Sequencer: optional find scan, apply, scan for the new best
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_cnt_q <= '0;
      count_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          scan_cnt_q <= '0;
          if (in_acc) begin
            if ((s_axis_tuser == KIND_DEQ) && (count_q != '0)) begin
              state_q <= S_FIND;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_FIND: begin
          if (scan_done) begin
            state_q <= S_EXEC;
          end else begin
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end
        end
        S_EXEC: begin
          scan_cnt_q <= '0;
          state_q    <= S_SCAN;
          case (kind_q)
            KIND_ENQ: begin
              if (not_full) begin
                count_q <= count_q + 1'b1;
              end
            end
            KIND_DEQ: begin
              if (count_q != '0) begin
                count_q <= count_q - 1'b1;
              end
            end
            KIND_CLEAR: begin
              count_q <= '0;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (!scan_done) begin
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Status and removed entry, settled in the apply cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      status_q     <= STAT_OK;
      taken_tag_q  <= '0;
      taken_prio_q <= '0;
      case (kind_q)
        KIND_ENQ: begin
          if (!not_full) begin
            status_q <= STAT_FULL;
          end
        end
        KIND_DEQ: begin
          if (count_q == '0) begin
            status_q <= STAT_EMPTY;
          end else begin
            taken_tag_q  <= carry_w[0].tag;
            taken_prio_q <= carry_w[0].prio;
          end
        end
        KIND_LOWER: begin
          if (!hit_w[0]) begin
            status_q <= STAT_NOMATCH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load at scan end, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_status_q     <= status_q;
      o_taken_tag_q  <= TAG_FIELD_W'(taken_tag_q);
      o_taken_prio_q <= taken_prio_q;
      o_count_q      <= count_q;
      o_empty_q      <= (count_q == '0);
      if ((count_q != '0) && carry_w[0].vld) begin
        o_best_tag_q  <= TAG_FIELD_W'(carry_w[0].tag);
        o_best_prio_q <= carry_w[0].prio;
      end else begin
        o_best_tag_q  <= '0;
        o_best_prio_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {2'b00, o_empty_q, o_count_q, o_best_prio_q, o_best_tag_q,
                          o_taken_prio_q, o_taken_tag_q};

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(DEPTH))
    else $error("entry count above table depth");

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> (carry_w[0].vld && (cnt_t'(carry_w[0].slot) < count_q)))
    else $error("dequeue without a valid scanned slot");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enq |=> (count_q == cnt_t'($past(count_q) + 1'b1)))
    else $error("enqueue did not advance the count");

  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (count_q != '0)) |-> carry_w[0].vld)
    else $error("scan ended without a candidate on a non-empty table");

endmodule

[hw/rtl/mptq_cell.sv]
// One table slot of the min-priority queue: holds one entry, runs one step
// of the minimum scan and one step of the newest-match search. Uses mptq_pkg.
module mptq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mptq_pkg::idx_t  idx_i,
  input  mptq_pkg::cmd_t  cmd_i,
  input  mptq_pkg::tag_t  nb_tag_i,
  input  mptq_pkg::prio_t nb_prio_i,
  input  mptq_pkg::cand_t carry_i,
  input  logic            hit_i,
  output mptq_pkg::tag_t  tag_o,
  output mptq_pkg::prio_t prio_o,
  output mptq_pkg::cand_t carry_o,
  output logic            hit_o
);
  import mptq_pkg::*;

  tag_t  tag_q;
  prio_t prio_q;
  cand_t carry_q, carry_d;
  logic  valid;
  logic  match;
  logic  own_wins;

  assign valid = cnt_t'(idx_i) < cmd_i.count;

  // Lower request: this slot matches if the tag agrees and the new priority is smaller
  assign match = cmd_i.lower && valid && (tag_q == cmd_i.tag) && (prio_q > cmd_i.prio);
  assign hit_o = hit_i | match;

  // Scan step: keep the newer candidate unless there is none or this valid entry is strictly smaller
  assign own_wins = valid && (!carry_i.vld || (prio_q < carry_i.prio));

  always_comb begin
    carry_d = carry_i;
    if (own_wins) begin
      carry_d.vld  = 1'b1;
      carry_d.slot = idx_i;
      carry_d.tag  = tag_q;
      carry_d.prio = prio_q;
    end
  end

  // Entry storage: write new, shift down from newer neighbor, or lower in place
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq && (cnt_t'(idx_i) == cmd_i.count)) begin
      tag_q  <= cmd_i.tag;
      prio_q <= cmd_i.prio;
    end else if (cmd_i.shift && (idx_i >= cmd_i.take_slot)) begin
      tag_q  <= nb_tag_i;
      prio_q <= nb_prio_i;
    end else if (match && !hit_i) begin
      prio_q <= cmd_i.prio;
    end
  end

  // Candidate register toward the older neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign tag_o   = tag_q;
  assign prio_o  = prio_q;
  assign carry_o = carry_q;

endmodule

[tb/min_priority_table_queue_tb.sv]
// Self-checking testbench for min_priority_table_queue: a directed table of
// requests, then about 1750 random ones, each checked against a local queue model.
// Depends on mptq_pkg and the RTL of min_priority_table_queue.
`timescale 1ns / 1ps

module min_priority_table_queue_tb;
  import mptq_pkg::*;

  localparam prio_t PRIO_MAX = 32'sh7FFF_FFFF;
  localparam prio_t PRIO_MIN = prio_t'(32'h8000_0000);
  localparam int    RANDOM_REQUESTS = 1750;

  // One result beat, field by field
  typedef struct packed {
    logic [1:0] status;
    tag_t       taken_tag;
    prio_t      taken_prio;
    tag_t       best_tag;
    prio_t      best_prio;
    logic [4:0] count;
    logic       empty;
  } queue_result_t;

  // One row of the directed table; a typed row carries its own expectation
  typedef struct {
    logic [1:0]    kind;
    tag_t          tag;
    prio_t         prio;
    int            reps;
    bit            typed;
    queue_result_t want;
  } request_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  // Model of the held entries, slot 0 oldest
  tag_t  held_tags [DEPTH];
  prio_t held_prios[DEPTH];
  int    held_count;

  queue_result_t pending_results[$];
  request_row_t  directed_rows[$];
  int            mismatches = 0;
  int            burst_left = 0;
  int            rx_mode;
  int            rx_left = 0;

  min_priority_table_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Newest entry with the smallest priority; held_count must be nonzero
  function automatic int urgent_slot();
    int best;
    best = held_count - 1;
    for (int i = held_count - 2; i >= 0; i--) begin
      if (held_prios[i] < held_prios[best]) best = i;
    end
    return best;
  endfunction

  // Apply one request to the model and return the result it should produce
  function automatic queue_result_t apply_request(logic [1:0] kind, tag_t tag, prio_t prio);
    queue_result_t res;
    int slot;
    bit hit;
    res = '0;
    res.status = STAT_OK;
    case (kind)
      KIND_ENQ: begin
        if (held_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          held_tags[held_count]  = tag;
          held_prios[held_count] = prio;
          held_count++;
        end
      end
      KIND_DEQ: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          slot = urgent_slot();
          res.taken_tag  = held_tags[slot];
          res.taken_prio = held_prios[slot];
          // close the gap, keeping age order
          for (int i = slot; i < held_count - 1; i++) begin
            held_tags[i]  = held_tags[i + 1];
            held_prios[i] = held_prios[i + 1];
          end
          held_count--;
        end
      end
      KIND_LOWER: begin
        hit = 1'b0;
        for (int i = held_count - 1; i >= 0 && !hit; i--) begin
          if (held_tags[i] == tag && held_prios[i] > prio) begin
            held_prios[i] = prio;
            hit = 1'b1;
          end
        end
        if (!hit) res.status = STAT_NOMATCH;
      end
      default: begin
        held_count = 0;
      end
    endcase
    if (held_count > 0) begin
      slot = urgent_slot();
      res.best_tag  = held_tags[slot];
      res.best_prio = held_prios[slot];
    end
    res.count = 5'(held_count);
    res.empty = (held_count == 0);
    return res;
  endfunction

  // Send one request beat; bursts of random length with random gaps between
  task automatic send_request(input logic [1:0] kind, input tag_t tag, input prio_t prio,
                              input bit typed, input queue_result_t want);
    int gap_len;
    queue_result_t res;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap_len    = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap_len) @(negedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, tag};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    res = apply_request(kind, tag, prio);
    pending_results.push_back(typed ? want : res);
  endtask

  // Random request, biased toward filling, draining or neither
  task automatic send_random_request(input int mode);
    int pick;
    logic [1:0] kind;
    tag_t tag;
    prio_t prio;
    pick = $urandom_range(0, 99);
    case (mode)
      0:       kind = pick < 60 ? KIND_ENQ : pick < 75 ? KIND_DEQ : pick < 97 ? KIND_LOWER : KIND_CLEAR;
      1:       kind = pick < 20 ? KIND_ENQ : pick < 75 ? KIND_DEQ : pick < 98 ? KIND_LOWER : KIND_CLEAR;
      default: kind = pick < 40 ? KIND_ENQ : pick < 70 ? KIND_DEQ : pick < 97 ? KIND_LOWER : KIND_CLEAR;
    endcase
    // reuse held tags often so that lowering finds a match
    if (held_count > 0 && $urandom_range(0, 1) == 1) begin
      tag = held_tags[$urandom_range(0, held_count - 1)];
    end else if ($urandom_range(0, 3) == 0) begin
      tag = tag_t'($urandom);
    end else begin
      tag = tag_t'($urandom_range(0, 7));
    end
    case ($urandom_range(0, 9))
      0: prio = prio_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       prio = PRIO_MIN;
          1:       prio = PRIO_MAX;
          2:       prio = 32'sd0;
          default: prio = -32'sd1;
        endcase
      end
      default: prio = prio_t'($urandom_range(0, 32)) - 32'sd16;
    endcase
    send_request(kind, tag, prio, 1'b0, '0);
  endtask

  function automatic void check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Receiver: stall on a pattern of its own, switching mode now and then
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Check every result beat against the oldest expectation
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("taken_tag", want.taken_tag, m_axis_tdata[15:0]);
        check_field("taken_prio", want.taken_prio, $signed(m_axis_tdata[47:16]));
        check_field("best_tag", want.best_tag, m_axis_tdata[63:48]);
        check_field("best_prio", want.best_prio, $signed(m_axis_tdata[95:64]));
        check_field("count", want.count, m_axis_tdata[100:96]);
        check_field("empty_res", want.empty, m_axis_tdata[101]);
      end
    end
  end

  initial begin
    int mode;
    int mode_left;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_ENQ;
    held_count    = 0;

    // empty-table errors, extremes, ties, lowering rules, full and drain
    directed_rows.push_back('{KIND_DEQ, 16'h0000, 32'sd0, 1, 1'b1,
                              '{STAT_EMPTY, 16'h0, 32'sd0, 16'h0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{KIND_LOWER, 16'h0000, 32'sd0, 1, 1'b1,
                              '{STAT_NOMATCH, 16'h0, 32'sd0, 16'h0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{KIND_CLEAR, 16'h0000, 32'sd0, 1, 1'b1,
                              '{STAT_OK, 16'h0, 32'sd0, 16'h0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{KIND_ENQ, 16'hFFFF, PRIO_MAX, 1, 1'b1,
                              '{STAT_OK, 16'h0, 32'sd0, 16'hFFFF, PRIO_MAX, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_ENQ, 16'h0000, PRIO_MIN, 1, 1'b1,
                              '{STAT_OK, 16'h0, 32'sd0, 16'h0000, PRIO_MIN, 5'd2, 1'b0}});
    directed_rows.push_back('{KIND_LOWER, 16'hFFFF, PRIO_MIN, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_LOWER, 16'hFFFF, PRIO_MIN, 1, 1'b1,
                              '{STAT_NOMATCH, 16'h0, 32'sd0, 16'h0000, PRIO_MIN, 5'd2, 1'b0}});
    directed_rows.push_back('{KIND_LOWER, 16'h1234, 32'sd0, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_DEQ, 16'h0000, 32'sd0, 2, 1'b0, '0});
    directed_rows.push_back('{KIND_ENQ, 16'hAAAA, 32'sd5, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_ENQ, 16'h5555, 32'sd5, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_ENQ, 16'hAAAA, 32'sd9, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_LOWER, 16'hAAAA, 32'sd7, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_LOWER, 16'hAAAA, 32'sd6, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_LOWER, 16'hAAAA, 32'sd5, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_DEQ, 16'h0000, 32'sd0, 1, 1'b0, '0});
    directed_rows.push_back('{KIND_CLEAR, 16'h0000, 32'sd0, 1, 1'b1,
                              '{STAT_OK, 16'h0, 32'sd0, 16'h0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{KIND_ENQ, 16'h0005, 32'sd0, DEPTH, 1'b0, '0});
    directed_rows.push_back('{KIND_ENQ, 16'h0001, -32'sd1, 1, 1'b1,
                              '{STAT_FULL, 16'h0, 32'sd0, 16'h0005, 32'sd0, 5'd16, 1'b0}});
    directed_rows.push_back('{KIND_DEQ, 16'h0000, 32'sd0, DEPTH, 1'b0, '0});
    directed_rows.push_back('{KIND_DEQ, 16'h0000, 32'sd0, 1, 1'b1,
                              '{STAT_EMPTY, 16'h0, 32'sd0, 16'h0, 32'sd0, 5'd0, 1'b1}});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_request(directed_rows[r].kind, directed_rows[r].tag, directed_rows[r].prio,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // random phase, switching bias every few dozen requests
    mode_left = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      send_random_request(mode);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then wait longer than a dequeue takes, for stray beats
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
